>>> rtl/mud_pkg.sv
// Shared types and constants for the meter upload deframer.
// Holds the transfer payload structs, item and result codes, and register indexes.
// No dependencies.
package mud_pkg;

    localparam logic [7:0]  REQ_BYTE          = 8'hAA;
    localparam logic [9:0]  TEN_BITS          = 10'h3FF;
    localparam logic [15:0] MAX_SAMPLES_RESET = 16'd4096;
    localparam logic [15:0] TIMEOUT_RESET     = 16'd200;
    localparam logic        PACKING_RESET     = 1'b1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NONE  = 2'd3
    } item_kind_t;

    typedef enum logic [2:0] {
        RES_REQUEST     = 3'd0,
        RES_SAMPLE      = 3'd1,
        RES_EMPTY       = 3'd2,
        RES_BAD_COUNT   = 3'd3,
        RES_COUNT_TMO   = 3'd4,
        RES_SAMPLE_TMO  = 3'd5
    } result_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PACKING_MODE    = 2'd0,
        REG_MAX_SAMPLES     = 2'd1,
        REG_BYTE_TIMEOUT_MS = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [7:0]  tx_byte;
        logic [31:0] sample_count;
        logic [15:0] sample_number;
        logic [15:0] sample_index;
        logic [15:0] pulse_count;
        logic        last_sample;
    } out_item_t;

endpackage

>>> rtl/mud_engine.sv
// Exchange state machine and configuration registers of the meter upload deframer.
// Takes one item per step strobe and produces at most one result combinationally.
// Depends on mud_pkg.
module mud_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [mud_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mud_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                step,
    input  mud_pkg::in_item_t                   item,
    output logic                                res_valid,
    output mud_pkg::out_item_t                  res
);

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_COUNT   = 2'd1,
        PH_SAMPLES = 2'd2
    } phase_t;

    logic        packing_mode_reg;
    logic [15:0] max_samples_reg;
    logic [15:0] byte_timeout_ms_reg;

    phase_t      phase_reg,         phase_next;
    logic [1:0]  hdr_seen_reg,      hdr_seen_next;
    logic [31:0] count_value_reg,   count_value_next;
    logic [15:0] samples_done_reg,  samples_done_next;
    logic [1:0]  smp_seen_reg,      smp_seen_next;
    logic [31:0] sample_shift_reg,  sample_shift_next;
    logic [15:0] idle_ticks_reg,    idle_ticks_next;
    logic [15:0] latest_index_reg,  latest_index_next;
    logic [15:0] latest_pulses_reg, latest_pulses_next;

    logic [15:0] ticks_inc;
    logic [31:0] count_word;
    logic [1:0]  hdr_inc;
    logic [31:0] shift_word;
    logic [2:0]  seen_inc;
    logic [2:0]  sample_size;
    logic [15:0] dec_index;
    logic [15:0] dec_pulses;
    logic [16:0] done_inc;
    logic        is_last;

    always_comb
    begin
        ticks_inc   = (idle_ticks_reg == 16'hFFFF) ? idle_ticks_reg : idle_ticks_reg + 16'd1;
        count_word  = {count_value_reg[23:0], item.rx_byte};
        hdr_inc     = hdr_seen_reg + 2'd1;
        shift_word  = {sample_shift_reg[23:0], item.rx_byte};
        seen_inc    = {1'b0, smp_seen_reg} + 3'd1;
        sample_size = packing_mode_reg ? 3'd3 : 3'd4;
        if (packing_mode_reg)
        begin
            dec_index  = {6'd0, shift_word[23:14] & mud_pkg::TEN_BITS};
            dec_pulses = {6'd0, shift_word[13:4] & mud_pkg::TEN_BITS};
        end
        else
        begin
            dec_index  = shift_word[31:16];
            dec_pulses = shift_word[15:0];
        end
        done_inc = {1'b0, samples_done_reg} + 17'd1;
        is_last  = ({15'd0, done_inc} == count_value_reg);
    end

    always_comb
    begin
        phase_next         = phase_reg;
        hdr_seen_next      = hdr_seen_reg;
        count_value_next   = count_value_reg;
        samples_done_next  = samples_done_reg;
        smp_seen_next      = smp_seen_reg;
        sample_shift_next  = sample_shift_reg;
        idle_ticks_next    = idle_ticks_reg;
        latest_index_next  = latest_index_reg;
        latest_pulses_next = latest_pulses_reg;
        res_valid          = 1'b0;
        res                = '0;

        if (step)
        begin
            case (item.kind)
                mud_pkg::KIND_START:
                begin
                    phase_next         = PH_COUNT;
                    hdr_seen_next      = 2'd0;
                    count_value_next   = '0;
                    samples_done_next  = '0;
                    smp_seen_next      = 2'd0;
                    sample_shift_next  = '0;
                    idle_ticks_next    = '0;
                    latest_index_next  = '0;
                    latest_pulses_next = '0;
                    res_valid          = 1'b1;
                    res.result_kind    = mud_pkg::RES_REQUEST;
                    res.tx_byte        = mud_pkg::REQ_BYTE;
                end
                mud_pkg::KIND_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        idle_ticks_next = ticks_inc;
                        if (ticks_inc >= byte_timeout_ms_reg)
                        begin
                            res_valid  = 1'b1;
                            phase_next = PH_IDLE;
                            if (phase_reg == PH_COUNT)
                            begin
                                res.result_kind = mud_pkg::RES_COUNT_TMO;
                            end
                            else
                            begin
                                res.result_kind   = mud_pkg::RES_SAMPLE_TMO;
                                res.sample_count  = count_value_reg;
                                res.sample_number = samples_done_reg;
                                res.sample_index  = latest_index_reg;
                                res.pulse_count   = latest_pulses_reg;
                            end
                        end
                    end
                end
                mud_pkg::KIND_BYTE:
                begin
                    if (phase_reg == PH_COUNT)
                    begin
                        idle_ticks_next  = '0;
                        count_value_next = count_word;
                        hdr_seen_next    = hdr_inc;
                        if (hdr_inc == 2'd0)
                        begin
                            if (count_word == 32'd0)
                            begin
                                res_valid       = 1'b1;
                                res.result_kind = mud_pkg::RES_EMPTY;
                                phase_next      = PH_IDLE;
                            end
                            else if (count_word > {16'd0, max_samples_reg})
                            begin
                                res_valid        = 1'b1;
                                res.result_kind  = mud_pkg::RES_BAD_COUNT;
                                res.sample_count = count_word;
                                phase_next       = PH_IDLE;
                            end
                            else
                            begin
                                phase_next        = PH_SAMPLES;
                                samples_done_next = '0;
                                smp_seen_next     = 2'd0;
                                sample_shift_next = '0;
                            end
                        end
                    end
                    else if (phase_reg == PH_SAMPLES)
                    begin
                        idle_ticks_next   = '0;
                        sample_shift_next = shift_word;
                        if (seen_inc < sample_size)
                        begin
                            smp_seen_next = seen_inc[1:0];
                        end
                        else
                        begin
                            res_valid          = 1'b1;
                            res.result_kind    = mud_pkg::RES_SAMPLE;
                            res.sample_count   = count_value_reg;
                            res.sample_number  = samples_done_reg;
                            res.sample_index   = dec_index;
                            res.pulse_count    = dec_pulses;
                            res.last_sample    = is_last;
                            latest_index_next  = dec_index;
                            latest_pulses_next = dec_pulses;
                            samples_done_next  = done_inc[15:0];
                            smp_seen_next      = 2'd0;
                            sample_shift_next  = '0;
                            if (is_last)
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            packing_mode_reg    <= mud_pkg::PACKING_RESET;
            max_samples_reg     <= mud_pkg::MAX_SAMPLES_RESET;
            byte_timeout_ms_reg <= mud_pkg::TIMEOUT_RESET;
            phase_reg           <= PH_IDLE;
            hdr_seen_reg        <= '0;
            count_value_reg     <= '0;
            samples_done_reg    <= '0;
            smp_seen_reg        <= '0;
            sample_shift_reg    <= '0;
            idle_ticks_reg      <= '0;
            latest_index_reg    <= '0;
            latest_pulses_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    mud_pkg::REG_PACKING_MODE:    packing_mode_reg    <= cfg_data[0];
                    mud_pkg::REG_MAX_SAMPLES:     max_samples_reg     <= cfg_data;
                    mud_pkg::REG_BYTE_TIMEOUT_MS: byte_timeout_ms_reg <= cfg_data;
                    default:                      packing_mode_reg    <= packing_mode_reg;
                endcase
            end
            phase_reg         <= phase_next;
            hdr_seen_reg      <= hdr_seen_next;
            count_value_reg   <= count_value_next;
            samples_done_reg  <= samples_done_next;
            smp_seen_reg      <= smp_seen_next;
            sample_shift_reg  <= sample_shift_next;
            idle_ticks_reg    <= idle_ticks_next;
            latest_index_reg  <= latest_index_next;
            latest_pulses_reg <= latest_pulses_next;
        end
    end

endmodule

>>> rtl/meter_upload_deframer_core.sv
// Top level of the meter upload deframer: input register, exchange engine, result register.
// Depends on mud_pkg and mud_engine.
//
// Meter upload deframer. A start item (kind 0) abandons any exchange in progress and
// returns the request byte 0xAA; received bytes (kind 1) then build a 4-byte big-endian
// sample count and the samples that follow, packed 16/16 in four bytes (packing_mode 0)
// or 10/10 in three bytes (packing_mode 1); millisecond ticks (kind 2) drive the
// inter-byte timeout. Each item gives zero or one result. Throughput is one item per
// clock while the output is not stalled: an accepted item is held in the input register,
// the engine processes it in a single pass when it advances, and its result, if any, is
// loaded into the result register, which drives out_valid. The input register advances
// whenever the result register is empty or being emptied in the same cycle; a stalled
// output holds back the input only once the input register is also occupied.
// Configuration writes are always taken (cfg_ready is tied high) and are meant to happen
// only while no item is in flight; a write to an index beyond the register list is
// ignored.
module meter_upload_deframer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mud_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mud_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mud_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mud_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // input stage
    logic               item_valid_reg, item_valid_next;
    mud_pkg::in_item_t  item_reg;

    // result stage
    logic               res_valid_reg, res_valid_next;
    mud_pkg::out_item_t res_reg;

    logic               advance;
    logic               eng_res_valid;
    mud_pkg::out_item_t eng_res;

    // The held item moves into the engine when the result slot is free this cycle.
    assign advance   = item_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;

    mud_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (advance),
        .item      (item_reg),
        .res_valid (eng_res_valid),
        .res       (eng_res)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (advance)
        begin
            item_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg && !out_ready;
        if (advance && eng_res_valid)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        if (advance && eng_res_valid)
        begin
            res_reg <= eng_res;
        end
    end

endmodule

>>> tb/meter_upload_deframer_core_tb.sv
// Testbench for meter_upload_deframer_core: directed exchanges, then random ones.
// Random input gaps and output stalls are applied outside quiet phases; a scoreboard predicts each result.
// Depends on mud_pkg and the RTL top level meter_upload_deframer_core.
module meter_upload_deframer_core_tb;

    localparam int RESET_CYCLES = 6;
    localparam int TARGET_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 8;          // pipeline is two deep, leave margin
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int TICK_RUN_MAX = 64;         // longest timeout we will tick out

    typedef enum logic [1:0] { XCH_IDLE, XCH_COUNT, XCH_SAMPLES } xch_phase_t;

    // Tracks the exchange state and queues the result each accepted item
    // should produce; results are checked in order against that queue.
    class upload_scoreboard;
        logic               packing;
        logic [15:0]        max_count;
        logic [15:0]        timeout_ms;
        xch_phase_t         phase;
        logic [1:0]         hdr_seen;
        logic [31:0]        count_word;
        logic [15:0]        done;
        logic [1:0]         bytes_seen;
        logic [31:0]        shift_word;
        logic [15:0]        quiet_ticks;
        logic [15:0]        last_idx;
        logic [15:0]        last_pul;
        mud_pkg::out_item_t pending[$];
        int unsigned        failures;
        int unsigned        matched;
        int unsigned        by_kind[6];

        function new();
            packing    = mud_pkg::PACKING_RESET;
            max_count  = mud_pkg::MAX_SAMPLES_RESET;
            timeout_ms = mud_pkg::TIMEOUT_RESET;
            phase      = XCH_IDLE;
            failures   = 0;
            matched    = 0;
            foreach (by_kind[k]) by_kind[k] = 0;
            drop_exchange();
        endfunction

        function void drop_exchange();
            hdr_seen    = '0;
            count_word  = '0;
            done        = '0;
            bytes_seen  = '0;
            shift_word  = '0;
            quiet_ticks = '0;
            last_idx    = '0;
            last_pul    = '0;
        endfunction

        function void set_register(mud_pkg::reg_index_t idx, logic [15:0] value);
            case (idx)
                mud_pkg::REG_PACKING_MODE:    packing    = value[0];
                mud_pkg::REG_MAX_SAMPLES:     max_count  = value;
                mud_pkg::REG_BYTE_TIMEOUT_MS: timeout_ms = value;
                default: ;
            endcase
        endfunction

        function void note_item(mud_pkg::in_item_t it);
            mud_pkg::out_item_t res;
            logic [2:0] size;
            logic [2:0] seen_n;
            res = '0;
            if (it.kind == mud_pkg::KIND_START)
            begin
                drop_exchange();
                phase           = XCH_COUNT;
                res.result_kind = mud_pkg::RES_REQUEST;
                res.tx_byte     = mud_pkg::REQ_BYTE;
                pending.push_back(res);
                return;
            end
            if (phase == XCH_IDLE || it.kind == mud_pkg::KIND_NONE) return;

            if (it.kind == mud_pkg::KIND_TICK)
            begin
                if (quiet_ticks != 16'hFFFF) quiet_ticks++;
                if (quiet_ticks < timeout_ms) return;
                if (phase == XCH_COUNT)
                    res.result_kind = mud_pkg::RES_COUNT_TMO;
                else
                begin
                    res.result_kind   = mud_pkg::RES_SAMPLE_TMO;
                    res.sample_count  = count_word;
                    res.sample_number = done;
                    res.sample_index  = last_idx;
                    res.pulse_count   = last_pul;
                end
                phase = XCH_IDLE;
                pending.push_back(res);
                return;
            end

            quiet_ticks = '0;
            if (phase == XCH_COUNT)
            begin
                count_word = {count_word[23:0], it.rx_byte};
                hdr_seen   = hdr_seen + 2'd1;
                if (hdr_seen != 2'd0) return;
                if (count_word == 32'd0)
                begin
                    res.result_kind = mud_pkg::RES_EMPTY;
                    phase = XCH_IDLE;
                    pending.push_back(res);
                end
                else if (count_word > {16'd0, max_count})
                begin
                    res.result_kind  = mud_pkg::RES_BAD_COUNT;
                    res.sample_count = count_word;
                    phase = XCH_IDLE;
                    pending.push_back(res);
                end
                else
                begin
                    phase      = XCH_SAMPLES;
                    done       = '0;
                    bytes_seen = '0;
                    shift_word = '0;
                end
                return;
            end

            // sample gathering; a packing change can leave more bytes than needed
            size       = packing ? 3'd3 : 3'd4;
            seen_n     = {1'b0, bytes_seen} + 3'd1;
            shift_word = {shift_word[23:0], it.rx_byte};
            if (seen_n < size)
            begin
                bytes_seen = seen_n[1:0];
                return;
            end
            res.result_kind   = mud_pkg::RES_SAMPLE;
            res.sample_count  = count_word;
            res.sample_number = done;
            if (packing)
            begin
                res.sample_index = {6'd0, shift_word[23:14]};
                res.pulse_count  = {6'd0, shift_word[13:4]};
            end
            else
            begin
                res.sample_index = shift_word[31:16];
                res.pulse_count  = shift_word[15:0];
            end
            res.last_sample = (({16'd0, done} + 32'd1) == count_word);
            last_idx   = res.sample_index;
            last_pul   = res.pulse_count;
            done++;
            bytes_seen = '0;
            shift_word = '0;
            if (res.last_sample) phase = XCH_IDLE;
            pending.push_back(res);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(mud_pkg::out_item_t got);
            mud_pkg::out_item_t want;
            if (pending.size() == 0)
            begin
                $error("result_kind: expected no result, got 0x%0h", got.result_kind);
                failures++;
                return;
            end
            want = pending.pop_front();
            compare_field("result_kind",   32'(want.result_kind),   32'(got.result_kind));
            compare_field("tx_byte",       32'(want.tx_byte),       32'(got.tx_byte));
            compare_field("sample_count",  want.sample_count,       got.sample_count);
            compare_field("sample_number", 32'(want.sample_number), 32'(got.sample_number));
            compare_field("sample_index",  32'(want.sample_index),  32'(got.sample_index));
            compare_field("pulse_count",   32'(want.pulse_count),   32'(got.pulse_count));
            compare_field("last_sample",   32'(want.last_sample),   32'(got.last_sample));
            matched++;
            by_kind[want.result_kind]++;
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    mud_pkg::in_item_t               in_data;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    mud_pkg::out_item_t              out_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [mud_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mud_pkg::CFG_DATA_W-1:0]  cfg_data;

    upload_scoreboard board;
    bit          quiet = 1'b0;      // no gaps and no stalls in this phase
    int          stall_left = 0;
    int unsigned cycles = 0;
    int unsigned items_sent = 0;
    int unsigned noise_sent = 0;
    int unsigned setups = 0;

    meter_upload_deframer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) board.check_result(out_data);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("** meter_upload_deframer_core: FAILED **");
            $finish;
        end
    end

    // One item transfer. Valid stays high between back-to-back items and is
    // only dropped when a gap is taken or the bench settles.
    task automatic push_item(input mud_pkg::item_kind_t k, input logic [7:0] b);
        mud_pkg::in_item_t it;
        int                gap;
        it.kind    = k;
        it.rx_byte = b;
        gap        = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_item(it);
        items_sent++;
    endtask

    // Byte, sometimes preceded by a few ticks that stay under the timeout.
    task automatic feed_byte(input logic [7:0] b);
        int n;
        n = 0;
        if (board.timeout_ms > 16'd1 && $urandom_range(0, 4) == 0)
            n = $urandom_range(1, (board.timeout_ms > 16'd4) ? 3 : board.timeout_ms - 1);
        repeat (n) push_item(mud_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
        push_item(mud_pkg::KIND_BYTE, b);
    endtask

    task automatic feed_count(input logic [31:0] cnt);
        for (int i = 3; i >= 0; i--) feed_byte(cnt[8*i +: 8]);
    endtask

    // Tick until the exchange ends; only used with short timeouts.
    task automatic tick_out();
        while (board.phase != XCH_IDLE)
            push_item(mud_pkg::KIND_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input mud_pkg::reg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_register(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Quiet point: nothing in flight and every expected result delivered.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_setup();
        int r;
        settle();
        setups++;
        if ($urandom_range(0, 2) != 0)
            write_reg(mud_pkg::REG_PACKING_MODE, 16'($urandom_range(0, 1)));
        if ($urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 9);
            write_reg(mud_pkg::REG_MAX_SAMPLES, (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF :
                      (r == 2) ? mud_pkg::MAX_SAMPLES_RESET : 16'($urandom_range(1, 24)));
        end
        if ($urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 9);
            write_reg(mud_pkg::REG_BYTE_TIMEOUT_MS, (r == 0) ? 16'd1 : (r == 1) ? 16'hFFFF :
                      (r == 2) ? mud_pkg::TIMEOUT_RESET : 16'($urandom_range(2, 40)));
        end
        quiet = ($urandom_range(0, 4) == 0);
    endtask

    // One exchange: mostly well formed, with empty, bad, abandoned and
    // timed-out variants and some idle noise.
    task automatic random_exchange();
        int          r;
        int          cut;
        int          sent;
        logic [31:0] cnt;
        logic [15:0] cap;
        logic [7:0]  b;
        r   = $urandom_range(0, 99);
        cap = board.max_count;
        if (r < 6)
        begin
            repeat ($urandom_range(1, 3))
            begin
                if (board.phase == XCH_IDLE && $urandom_range(0, 2) != 0)
                    push_item($urandom_range(0, 1) ? mud_pkg::KIND_BYTE : mud_pkg::KIND_TICK,
                              8'($urandom_range(0, 255)));
                else
                    push_item(mud_pkg::KIND_NONE, 8'($urandom_range(0, 255)));
                noise_sent++;
            end
            return;
        end
        push_item(mud_pkg::KIND_START, 8'($urandom_range(0, 255)));
        if (r < 16)
        begin
            // count phase cut short: tick out or leave for the next start
            repeat ($urandom_range(0, 3)) feed_byte(8'($urandom_range(0, 255)));
            if (board.timeout_ms <= TICK_RUN_MAX) tick_out();
            return;
        end
        // oversized counts always sit above the 16-bit cap
        if (r < 21)
            cnt = 32'd0;
        else if (r < 28)
            cnt = (cap == 16'hFFFF || $urandom_range(0, 1)) ? ($urandom | 32'h0001_0000) :
                  {16'd0, cap} + 32'd1;
        else if (r < 33)
            cnt = (cap <= 16'd40) ? {16'd0, cap} : $urandom_range(7, 40);
        else
            cnt = $urandom_range(1, (cap < 16'd6) ? cap : 6);
        feed_count(cnt);
        if (board.phase != XCH_SAMPLES) return;

        r    = $urandom_range(0, 99);
        cut  = (r < 16) ? $urandom_range(0, cnt * 4 - 1) : -1;
        sent = 0;
        while (board.phase == XCH_SAMPLES && sent != cut)
        begin
            case ($urandom_range(0, 9))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            feed_byte(b);
            sent++;
        end
        if (r < 9 && board.timeout_ms <= TICK_RUN_MAX) tick_out();
    endtask

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: idle noise, one 3-byte sample of all ones, a bad count
        // of all ones, a start that abandons a partial count, and an empty count.
        push_item(mud_pkg::KIND_BYTE, 8'h5A);
        push_item(mud_pkg::KIND_TICK, 8'h00);
        push_item(mud_pkg::KIND_NONE, 8'hFF);
        noise_sent += 3;
        push_item(mud_pkg::KIND_START, 8'h00);
        feed_count(32'd1);
        repeat (3) feed_byte(8'hFF);
        push_item(mud_pkg::KIND_START, 8'hFF);
        feed_count(32'hFFFF_FFFF);
        push_item(mud_pkg::KIND_START, 8'h00);
        feed_byte(8'h00);
        push_item(mud_pkg::KIND_START, 8'h00);
        feed_count(32'd0);

        // 4-byte samples, then a switch to 3-byte packing in the middle of a
        // sample, then a sample timeout on the first tick.
        settle();
        write_reg(mud_pkg::REG_PACKING_MODE, 16'd0);
        write_reg(mud_pkg::REG_MAX_SAMPLES, 16'hFFFF);
        write_reg(mud_pkg::REG_BYTE_TIMEOUT_MS, 16'd1);
        push_item(mud_pkg::KIND_START, 8'h00);
        feed_count(32'd3);
        repeat (4) feed_byte(8'hFF);
        feed_byte(8'h00);
        feed_byte(8'h12);
        feed_byte(8'h34);
        settle();
        write_reg(mud_pkg::REG_PACKING_MODE, 16'd1);
        feed_byte(8'h56);
        push_item(mud_pkg::KIND_TICK, 8'h00);

        // Zero limits: every nonzero count is bad, the first tick times out.
        settle();
        write_reg(mud_pkg::REG_MAX_SAMPLES, 16'd0);
        write_reg(mud_pkg::REG_BYTE_TIMEOUT_MS, 16'd0);
        push_item(mud_pkg::KIND_START, 8'h00);
        push_item(mud_pkg::KIND_TICK, 8'h00);
        push_item(mud_pkg::KIND_START, 8'h00);
        feed_count(32'd1);

        settle();
        write_reg(mud_pkg::REG_MAX_SAMPLES, mud_pkg::MAX_SAMPLES_RESET);
        write_reg(mud_pkg::REG_BYTE_TIMEOUT_MS, 16'd20);

        while (items_sent - noise_sent < TARGET_ITEMS)
        begin
            random_setup();
            repeat ($urandom_range(3, 8)) random_exchange();
        end
        settle();

        $display("Run covered %0d items (%0d ignored) over %0d register settings, %0d results.",
                 items_sent, noise_sent, setups + 3, board.matched);
        $display("Results: request %0d, sample %0d, empty %0d, bad count %0d, %s %0d, %s %0d",
                 board.by_kind[mud_pkg::RES_REQUEST], board.by_kind[mud_pkg::RES_SAMPLE],
                 board.by_kind[mud_pkg::RES_EMPTY], board.by_kind[mud_pkg::RES_BAD_COUNT],
                 "count timeout", board.by_kind[mud_pkg::RES_COUNT_TMO],
                 "sample timeout", board.by_kind[mud_pkg::RES_SAMPLE_TMO]);
        if (board.failures == 0 && board.pending.size() == 0)
            $display("** meter_upload_deframer_core: PASSED **");
        else
            $display("** meter_upload_deframer_core: FAILED **");
        $finish;
    end

endmodule

>>> files.f
rtl/mud_pkg.sv
rtl/mud_engine.sv
rtl/meter_upload_deframer_core.sv
tb/meter_upload_deframer_core_tb.sv
